// ----- src/sbsc_pkg.sv -----
// Shared types and constants for the segment/box slab clipper.
package sbsc_pkg;

   localparam int COORD_WIDTH    = 16;
   localparam int FRACTION_WIDTH = 16;
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   // register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_BOX_MIN_X = 2'd0;
   localparam logic [1:0] REG_BOX_MIN_Y = 2'd1;
   localparam logic [1:0] REG_BOX_MAX_X = 2'd2;
   localparam logic [1:0] REG_BOX_MAX_Y = 2'd3;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] offset_x;
      logic signed [COORD_WIDTH-1:0] offset_y;
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic                             hit;
      logic        [FRACTION_WIDTH-1:0] hit_fraction;
      logic signed [COORD_WIDTH-1:0]    hit_x;
      logic signed [COORD_WIDTH-1:0]    hit_y;
   } rsp_type;

endpackage

// ----- src/segment_box_slab_clip_top.sv -----
// Segment versus offset box slab clipper: config registers and full pipeline.
// Throughput: one item per cycle unless rsp stalls; four restoring dividers run
// one quotient bit per stage, so the divider chain sets the pipeline depth.
// A stall on rsp freezes every stage together; req_ready drops while stalled.
// Reset (synchronous, active high) clears all valid bits and the box registers.
module segment_box_slab_clip_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  sbsc_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output sbsc_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [sbsc_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [sbsc_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [sbsc_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   localparam int CW = sbsc_pkg::COORD_WIDTH;
   localparam int FW = sbsc_pkg::FRACTION_WIDTH;
   localparam int AW = CW + 1;        // shifted box bound
   localparam int DW = CW + 1;        // segment direction
   localparam int NW = CW + 2;        // bound minus start, divider remainder
   localparam int QW = FW + 1;        // quotient bits kept
   localparam int TW = FW + 3;        // clamped slab parameter, signed
   localparam int PW = DW + FW + 1;   // entry point product
   localparam int DWN = sbsc_pkg::CSR_DATA_WIDTH;

   localparam logic signed [TW-1:0] T_ONE  = TW'(2**FW);
   localparam logic signed [TW-1:0] T_OVER = TW'(2**FW + 1);
   localparam logic signed [PW-1:0] P_RND  = PW'(2**FW - 1);

   // one divider lane: |bound - start| / |direction|
   typedef struct packed {
      logic          neg;
      logic          ovf;
      logic [DW-1:0] den;
      logic [NW-1:0] rem;
      logic [QW-1:0] quo;
   } lane_type;

   // everything that rides along with an item through the dividers
   typedef struct packed {
      logic                   valid;
      logic signed [CW-1:0]   sx;
      logic signed [CW-1:0]   sy;
      logic signed [DW-1:0]   dx;
      logic signed [DW-1:0]   dy;
      logic                   par_x;
      logic                   in_x;
      logic                   par_y;
      logic                   in_y;
      lane_type [3:0]         lanes;   // 0: min x, 1: max x, 2: min y, 3: max y
   } div_type;

   // ---------------- configuration registers ----------------
   logic signed [CW-1:0] box_min_x_ff, box_min_y_ff, box_max_x_ff, box_max_y_ff;
   logic [1:0] csr_index;
   logic       csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_min_x_ff <= '0;
         box_min_y_ff <= '0;
         box_max_x_ff <= '0;
         box_max_y_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            sbsc_pkg::REG_BOX_MIN_X: box_min_x_ff <= csr_pwdata[CW-1:0];
            sbsc_pkg::REG_BOX_MIN_Y: box_min_y_ff <= csr_pwdata[CW-1:0];
            sbsc_pkg::REG_BOX_MAX_X: box_max_x_ff <= csr_pwdata[CW-1:0];
            sbsc_pkg::REG_BOX_MAX_Y: box_max_y_ff <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         sbsc_pkg::REG_BOX_MIN_X: csr_prdata = DWN'({1'b0, box_min_x_ff});
         sbsc_pkg::REG_BOX_MIN_Y: csr_prdata = DWN'({1'b0, box_min_y_ff});
         sbsc_pkg::REG_BOX_MAX_X: csr_prdata = DWN'({1'b0, box_max_x_ff});
         sbsc_pkg::REG_BOX_MAX_Y: csr_prdata = DWN'({1'b0, box_max_y_ff});
         default:                 csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline advance ----------------
   // the whole pipe moves together; the last stage is the output register
   logic adv;
   logic h_valid_ff;

   assign adv       = !h_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage A: shift box, direction ----------------
   logic                 a_valid_ff, a_valid_in;
   logic signed [AW-1:0] a_ax_ff, a_bx_ff, a_ay_ff, a_by_ff;
   logic signed [AW-1:0] a_ax_in, a_bx_in, a_ay_in, a_by_in;
   logic signed [CW-1:0] a_sx_ff, a_sy_ff;
   logic signed [DW-1:0] a_dx_ff, a_dy_ff, a_dx_in, a_dy_in;

   assign a_valid_in = req_valid;
   assign a_ax_in = $signed({box_min_x_ff[CW-1], box_min_x_ff})
                  + $signed({req_data.offset_x[CW-1], req_data.offset_x});
   assign a_bx_in = $signed({box_max_x_ff[CW-1], box_max_x_ff})
                  + $signed({req_data.offset_x[CW-1], req_data.offset_x});
   assign a_ay_in = $signed({box_min_y_ff[CW-1], box_min_y_ff})
                  + $signed({req_data.offset_y[CW-1], req_data.offset_y});
   assign a_by_in = $signed({box_max_y_ff[CW-1], box_max_y_ff})
                  + $signed({req_data.offset_y[CW-1], req_data.offset_y});
   assign a_dx_in = $signed({req_data.end_x[CW-1], req_data.end_x})
                  - $signed({req_data.start_x[CW-1], req_data.start_x});
   assign a_dy_in = $signed({req_data.end_y[CW-1], req_data.end_y})
                  - $signed({req_data.start_y[CW-1], req_data.start_y});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ax_ff <= a_ax_in;
         a_bx_ff <= a_bx_in;
         a_ay_ff <= a_ay_in;
         a_by_ff <= a_by_in;
         a_sx_ff <= req_data.start_x;
         a_sy_ff <= req_data.start_y;
         a_dx_ff <= a_dx_in;
         a_dy_ff <= a_dy_in;
      end
   end

   // ---------------- stage B: magnitudes, signs, parallel test ----------------
   div_type b_ff, b_in;

   always_comb begin
      logic signed [AW-1:0] bnd [4];
      logic signed [CW-1:0] st  [4];
      logic signed [DW-1:0] dir [4];
      logic signed [NW-1:0] num;
      logic signed [AW-1:0] s_ext_x, s_ext_y;
      bnd[0] = a_ax_ff; bnd[1] = a_bx_ff; bnd[2] = a_ay_ff; bnd[3] = a_by_ff;
      st[0]  = a_sx_ff; st[1]  = a_sx_ff; st[2]  = a_sy_ff; st[3]  = a_sy_ff;
      dir[0] = a_dx_ff; dir[1] = a_dx_ff; dir[2] = a_dy_ff; dir[3] = a_dy_ff;
      b_in = '0;
      b_in.valid = a_valid_ff;
      b_in.sx    = a_sx_ff;
      b_in.sy    = a_sy_ff;
      b_in.dx    = a_dx_ff;
      b_in.dy    = a_dy_ff;
      s_ext_x    = AW'(a_sx_ff);
      s_ext_y    = AW'(a_sy_ff);
      b_in.par_x = (a_dx_ff == '0);
      b_in.par_y = (a_dy_ff == '0);
      // inclusive, either corner order
      b_in.in_x  = ((s_ext_x >= a_ax_ff) && (s_ext_x <= a_bx_ff))
                || ((s_ext_x >= a_bx_ff) && (s_ext_x <= a_ax_ff));
      b_in.in_y  = ((s_ext_y >= a_ay_ff) && (s_ext_y <= a_by_ff))
                || ((s_ext_y >= a_by_ff) && (s_ext_y <= a_ay_ff));
      for (int i = 0; i < 4; i++) begin
         num = NW'(bnd[i]) - NW'(st[i]);
         b_in.lanes[i].neg = num[NW-1] ^ dir[i][DW-1];
         b_in.lanes[i].ovf = 1'b0;
         b_in.lanes[i].den = dir[i][DW-1] ? DW'(-dir[i]) : DW'(dir[i]);
         b_in.lanes[i].rem = num[NW-1] ? NW'(-num) : NW'(num);
         b_in.lanes[i].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ff.valid <= 1'b0;
      end else if (adv) begin
         b_ff.valid <= b_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_ff.sx    <= b_in.sx;
         b_ff.sy    <= b_in.sy;
         b_ff.dx    <= b_in.dx;
         b_ff.dy    <= b_in.dy;
         b_ff.par_x <= b_in.par_x;
         b_ff.in_x  <= b_in.in_x;
         b_ff.par_y <= b_in.par_y;
         b_ff.in_y  <= b_in.in_y;
         b_ff.lanes <= b_in.lanes;
      end
   end

   // ---------------- divider chain ----------------
   // stage 0: overflow check (quotient two or more) and integer bit
   // stages 1..FW: one fraction bit each
   div_type div_ff [FW+1];
   div_type div_in [FW+1];

   always_comb begin
      logic [NW-1:0] den_ext;
      logic          qbit;
      div_in[0] = b_ff;
      for (int i = 0; i < 4; i++) begin
         den_ext = NW'(b_ff.lanes[i].den);
         qbit    = b_ff.lanes[i].rem >= den_ext;
         div_in[0].lanes[i].ovf = b_ff.lanes[i].rem >= {b_ff.lanes[i].den, 1'b0};
         div_in[0].lanes[i].rem = qbit ? b_ff.lanes[i].rem - den_ext
                                       : b_ff.lanes[i].rem;
         div_in[0].lanes[i].quo = QW'(qbit);
      end
   end

   for (genvar k = 1; k <= FW; k++) begin : g_frac
      always_comb begin
         logic [NW:0] r2;
         logic [NW:0] den_ext;
         logic        qbit;
         div_in[k] = div_ff[k-1];
         for (int i = 0; i < 4; i++) begin
            r2      = {div_ff[k-1].lanes[i].rem, 1'b0};
            den_ext = (NW+1)'(div_ff[k-1].lanes[i].den);
            qbit    = r2 >= den_ext;
            div_in[k].lanes[i].rem = qbit ? NW'(r2 - den_ext) : NW'(r2);
            div_in[k].lanes[i].quo = {div_ff[k-1].lanes[i].quo[QW-2:0], qbit};
         end
      end
   end

   for (genvar k = 0; k <= FW; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k].valid <= 1'b0;
         end else if (adv) begin
            div_ff[k].valid <= div_in[k].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            div_ff[k].sx    <= div_in[k].sx;
            div_ff[k].sy    <= div_in[k].sy;
            div_ff[k].dx    <= div_in[k].dx;
            div_ff[k].dy    <= div_in[k].dy;
            div_ff[k].par_x <= div_in[k].par_x;
            div_ff[k].in_x  <= div_in[k].in_x;
            div_ff[k].par_y <= div_in[k].par_y;
            div_ff[k].in_y  <= div_in[k].in_y;
            div_ff[k].lanes <= div_in[k].lanes;
         end
      end
   end

   // ---------------- stage E: sign, clamp, order entry/exit ----------------
   // Slab parameters are clamped to [-1, ONE+1]; every later compare is
   // against a bound inside [0, ONE], so the clamp changes no decision.
   logic                 e_valid_ff;
   logic signed [CW-1:0] e_sx_ff, e_sy_ff;
   logic signed [DW-1:0] e_dx_ff, e_dy_ff;
   logic                 e_par_x_ff, e_in_x_ff, e_par_y_ff, e_in_y_ff;
   logic signed [TW-1:0] e_enter_x_ff, e_leave_x_ff, e_enter_y_ff, e_leave_y_ff;
   logic signed [TW-1:0] e_enter_x_in, e_leave_x_in, e_enter_y_in, e_leave_y_in;

   always_comb begin
      logic signed [TW-1:0] t [4];
      logic signed [TW-1:0] mag;
      for (int i = 0; i < 4; i++) begin
         mag = $signed(TW'(div_ff[FW].lanes[i].quo));
         if (div_ff[FW].lanes[i].neg) begin
            t[i] = (mag == '0 && !div_ff[FW].lanes[i].ovf) ? '0 : -TW'(1);
         end else begin
            t[i] = (div_ff[FW].lanes[i].ovf || mag > T_OVER) ? T_OVER : mag;
         end
      end
      e_enter_x_in = (t[1] < t[0]) ? t[1] : t[0];
      e_leave_x_in = (t[1] < t[0]) ? t[0] : t[1];
      e_enter_y_in = (t[3] < t[2]) ? t[3] : t[2];
      e_leave_y_in = (t[3] < t[2]) ? t[2] : t[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (adv) begin
         e_valid_ff <= div_ff[FW].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_sx_ff      <= div_ff[FW].sx;
         e_sy_ff      <= div_ff[FW].sy;
         e_dx_ff      <= div_ff[FW].dx;
         e_dy_ff      <= div_ff[FW].dy;
         e_par_x_ff   <= div_ff[FW].par_x;
         e_in_x_ff    <= div_ff[FW].in_x;
         e_par_y_ff   <= div_ff[FW].par_y;
         e_in_y_ff    <= div_ff[FW].in_y;
         e_enter_x_ff <= e_enter_x_in;
         e_leave_x_ff <= e_leave_x_in;
         e_enter_y_ff <= e_enter_y_in;
         e_leave_y_ff <= e_leave_y_in;
      end
   end

   // ---------------- stage F: clip x then y ----------------
   logic                 f_valid_ff;
   logic                 f_hit_ff, f_hit_in;
   logic [FW-1:0]        f_low_ff, f_low_in;
   logic signed [CW-1:0] f_sx_ff, f_sy_ff;
   logic signed [DW-1:0] f_dx_ff, f_dy_ff;

   always_comb begin
      logic                 ok_x, ok_y;
      logic signed [TW-1:0] lo1, hi1, lo2, hi2;
      if (e_par_x_ff) begin
         ok_x = e_in_x_ff;
         lo1  = '0;
         hi1  = T_ONE;
      end else begin
         lo1  = (e_enter_x_ff > 0) ? e_enter_x_ff : '0;
         hi1  = (e_leave_x_ff < T_ONE) ? e_leave_x_ff : T_ONE;
         ok_x = !(e_leave_x_ff < 0) && !(e_enter_x_ff > T_ONE) && (lo1 <= hi1);
      end
      if (e_par_y_ff) begin
         ok_y = e_in_y_ff;
         lo2  = lo1;
         hi2  = hi1;
      end else begin
         lo2  = (e_enter_y_ff > lo1) ? e_enter_y_ff : lo1;
         hi2  = (e_leave_y_ff < hi1) ? e_leave_y_ff : hi1;
         ok_y = !(e_leave_y_ff < lo1) && !(e_enter_y_ff > hi1) && (lo2 <= hi2);
      end
      f_hit_in = ok_x && ok_y && (lo2 < T_ONE);
      f_low_in = f_hit_in ? lo2[FW-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= e_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_hit_ff <= f_hit_in;
         f_low_ff <= f_low_in;
         f_sx_ff  <= e_sx_ff;
         f_sy_ff  <= e_sy_ff;
         f_dx_ff  <= e_dx_ff;
         f_dy_ff  <= e_dy_ff;
      end
   end

   // ---------------- stage G: direction times fraction ----------------
   logic                 g_valid_ff;
   logic                 g_hit_ff;
   logic [FW-1:0]        g_low_ff;
   logic signed [CW-1:0] g_sx_ff, g_sy_ff;
   logic signed [PW-1:0] g_px_ff, g_py_ff, g_px_in, g_py_in;

   assign g_px_in = PW'(f_dx_ff) * PW'($signed({1'b0, f_low_ff}));
   assign g_py_in = PW'(f_dy_ff) * PW'($signed({1'b0, f_low_ff}));

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         g_hit_ff <= f_hit_ff;
         g_low_ff <= f_low_ff;
         g_sx_ff  <= f_sx_ff;
         g_sy_ff  <= f_sy_ff;
         g_px_ff  <= g_px_in;
         g_py_ff  <= g_py_in;
      end
   end

   // ---------------- stage H: scale down toward zero, add start ----------------
   sbsc_pkg::rsp_type h_data_ff, h_data_in;
   logic              h_valid_in;

   always_comb begin
      logic signed [PW-1:0] qx, qy;
      qx = (g_px_ff < 0) ? ((g_px_ff + P_RND) >>> FW) : (g_px_ff >>> FW);
      qy = (g_py_ff < 0) ? ((g_py_ff + P_RND) >>> FW) : (g_py_ff >>> FW);
      h_valid_in = g_valid_ff;
      h_data_in  = '0;
      if (g_hit_ff) begin
         h_data_in.hit          = 1'b1;
         h_data_in.hit_fraction = g_low_ff;
         h_data_in.hit_x        = g_sx_ff + qx[CW-1:0];
         h_data_in.hit_y        = g_sy_ff + qy[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (adv) begin
         h_valid_ff <= h_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         h_data_ff <= h_data_in;
      end
   end

   assign rsp_valid = h_valid_ff;
   assign rsp_data  = h_data_ff;

   // ---------------- assertions ----------------
   // a miss carries all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |->
         rsp_data.hit_fraction == '0 && rsp_data.hit_x == '0 && rsp_data.hit_y == '0)
      else $error("miss item has nonzero fields");

   // lane 0 remainder stays below its nonzero divisor at the end of the chain (no overflow)
   assert property (@(posedge clock) disable iff (reset)
      div_ff[FW].valid && div_ff[FW].lanes[0].den != '0 && !div_ff[FW].lanes[0].ovf |->
         div_ff[FW].lanes[0].rem < NW'(div_ff[FW].lanes[0].den))
      else $error("divider remainder out of range");

   // entry never after exit once ordered
   assert property (@(posedge clock) disable iff (reset)
      e_valid_ff |-> e_enter_x_ff <= e_leave_x_ff && e_enter_y_ff <= e_leave_y_ff)
      else $error("slab entry past exit");

   // a stalled output register holds; the pipe behind it holds too
   assert property (@(posedge clock) disable iff (reset)
      h_valid_ff && !rsp_ready |=> $stable(g_px_ff) && $stable(f_low_ff))
      else $error("pipeline moved during stall");

endmodule
